### rtl/pip_pkg.sv
`default_nettype none

package pip_pkg;

    // default sizes of the polygon store and of one coordinate
    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;

    // fixed field and register widths
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // register index, taken from paddr above the byte offset
    localparam logic [CFG_ADDR_W-3:0] REG_VERTEX_COUNT = '0;

    // func field codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // item kind after classification
    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // head of queue as seen by the back part
    typedef struct packed
    {
        logic              valid;
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
    } q_head_t;

    // back part sequencer
    typedef enum logic [1:0]
    {
        BK_IDLE  = 2'd0,
        BK_WALK  = 2'd1,
        BK_DRAIN = 2'd2
    } bk_state_t;

endpackage

`default_nettype wire

### rtl/point_in_polygon_test.sv
// point in polygon test, ray-casting crossing parity over up to MAX_VERTICES stored vertices
// throughput: the back walk reads one vertex per cycle from the store;
// a two-item queue lets start be taken while a query runs
// results are strobed on done for one cycle; the receiver cannot stall
// reset: rst_n async active low clears control and vertex_count; vertex store is not cleared
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           func,
    input  wire logic [pip_pkg::SLOT_W-1:0]     vertex_index,
    input  wire logic [COORD_BITS-1:0]          coord_x,
    input  wire logic [COORD_BITS-1:0]          coord_y,
    output logic                                done,
    output logic                                inside_res,
    output logic                                on_boundary,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pip_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pip_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pip_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import pip_pkg::*;

    logic [COUNT_W-1:0]    vertex_count_reg;
    logic                  cfg_write;
    q_head_t               q_head;
    logic [COORD_BITS-1:0] q_x, q_y;
    logic                  q_pop;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (cfg_write && (paddr[CFG_ADDR_W-1:2] == REG_VERTEX_COUNT))
        begin
            vertex_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // register readback
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_VERTEX_COUNT)
                  ? CFG_DATA_W'(vertex_count_reg) : '0;

    // front: accepts and classifies items into the queue
    pip_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .q_head       (q_head),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_pop        (q_pop)
    );

    // back: vertex store and edge walk
    pip_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_count (vertex_count_reg),
        .q_head       (q_head),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_pop        (q_pop),
        .done         (done),
        .inside_res   (inside_res),
        .on_boundary  (on_boundary)
    );

endmodule

`default_nettype wire

### rtl/pip_front.sv
`default_nettype none

module pip_front #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        func,
    input  wire logic [pip_pkg::SLOT_W-1:0]  vertex_index,
    input  wire logic [COORD_BITS-1:0]       coord_x,
    input  wire logic [COORD_BITS-1:0]       coord_y,
    output pip_pkg::q_head_t                 q_head,
    output logic [COORD_BITS-1:0]            q_x,
    output logic [COORD_BITS-1:0]            q_y,
    input  wire logic                        q_pop
);
    import pip_pkg::*;

    kind_t             kind_mem [Q_DEPTH];
    logic [SLOT_W-1:0] slot_mem [Q_DEPTH];
    logic [COORD_BITS-1:0] x_mem [Q_DEPTH];
    logic [COORD_BITS-1:0] y_mem [Q_DEPTH];

    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    logic  accept;
    logic  slot_ok;
    logic  push;
    kind_t kind_in;

    // classify the item: writes to a slot beyond the store are dropped
    assign accept  = start && !busy;
    assign slot_ok = 32'(vertex_index) < MAX_VERTICES;
    assign kind_in = (func == FUNC_QUERY) ? KIND_QUERY : KIND_WRITE;
    assign push    = accept && ((kind_in == KIND_QUERY) || slot_ok);

    assign busy = (cnt_reg == Q_CNT_W'(Q_DEPTH));

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_mem[wr_ptr_reg] <= kind_in;
            slot_mem[wr_ptr_reg] <= vertex_index;
            x_mem[wr_ptr_reg]    <= coord_x;
            y_mem[wr_ptr_reg]    <= coord_y;
        end
    end

    // head of queue
    assign q_head.valid = (cnt_reg != '0);
    assign q_head.kind  = kind_mem[rd_ptr_reg];
    assign q_head.slot  = slot_mem[rd_ptr_reg];
    assign q_x          = x_mem[rd_ptr_reg];
    assign q_y          = y_mem[rd_ptr_reg];

endmodule

`default_nettype wire

### rtl/pip_back.sv
`default_nettype none

module pip_back #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [pip_pkg::COUNT_W-1:0] vertex_count,
    input  wire pip_pkg::q_head_t            q_head,
    input  wire logic [COORD_BITS-1:0]       q_x,
    input  wire logic [COORD_BITS-1:0]       q_y,
    output logic                             q_pop,
    output logic                             done,
    output logic                             inside_res,
    output logic                             on_boundary
);
    import pip_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;

    // vertex store
    logic [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0] vy_mem [MAX_VERTICES];

    bk_state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic [COORD_BITS-1:0] px_reg, py_reg;

    logic          rd_en, rd_first, rd_last;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          load_query, empty_query;

    logic [CMPW-1:0] cnt_ext, max_ext;
    logic [CW-1:0]   n_used, n_last;

    // stage 1: registered read data
    logic                  s1_v_reg, s1_first_reg, s1_last_reg;
    logic [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic [COORD_BITS-1:0] b_x_reg, b_y_reg;

    // stage 2: products and edge flags
    logic                 s2_v_reg, s2_last_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg;
    logic                 bbox_reg, straddle_reg, dy_pos_reg;

    logic signed [DW-1:0] dxba, dypa, dyba, dxpa;
    logic                 bbox_x, bbox_y, straddle, dy_pos;

    logic same, hit, edge_next, par_next;
    logic edge_reg, par_reg;
    logic done_reg, inside_reg, on_reg;

    // clamp the vertex count to the store depth
    assign cnt_ext = CMPW'(vertex_count);
    assign max_ext = CMPW'(MAX_VERTICES);
    assign n_used  = (cnt_ext > max_ext) ? CW'(max_ext) : CW'(cnt_ext);
    assign n_last  = CW'(n_used - 1'b1);

    // sequencer: one vertex read per cycle, last vertex first
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_first    = 1'b0;
        rd_last     = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        load_query  = 1'b0;
        empty_query = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.kind == KIND_WRITE)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (n_used == '0)
                    begin
                        empty_query = 1'b1;
                    end
                    else
                    begin
                        load_query = 1'b1;
                        rd_en      = 1'b1;
                        rd_first   = 1'b1;
                        rd_addr    = n_last[AW-1:0];
                        idx_next   = '0;
                        state_next = BK_WALK;
                    end
                end
            end
            BK_WALK:
            begin
                rd_en    = 1'b1;
                rd_addr  = idx_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_last[AW-1:0])
                begin
                    rd_last    = 1'b1;
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (s2_v_reg && s2_last_reg)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // query point
    always_ff @(posedge clk)
    begin
        if (load_query)
        begin
            px_reg <= q_x;
            py_reg <= q_y;
        end
    end

    // vertex store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vx_mem[AW'(q_head.slot)] <= q_x;
            vy_mem[AW'(q_head.slot)] <= q_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= vx_mem[rd_addr];
            rd_y_reg <= vy_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg     <= rd_en;
            s1_first_reg <= rd_first;
            s1_last_reg  <= rd_last;
        end
    end

    // edge a = current vertex, b = previous one
    assign dxba = $signed({1'b0, b_x_reg}) - $signed({1'b0, rd_x_reg});
    assign dyba = $signed({1'b0, b_y_reg}) - $signed({1'b0, rd_y_reg});
    assign dxpa = $signed({1'b0, px_reg}) - $signed({1'b0, rd_x_reg});
    assign dypa = $signed({1'b0, py_reg}) - $signed({1'b0, rd_y_reg});

    assign bbox_x   = ((px_reg >= rd_x_reg) && (px_reg <= b_x_reg))
                   || ((px_reg >= b_x_reg) && (px_reg <= rd_x_reg));
    assign bbox_y   = ((py_reg >= rd_y_reg) && (py_reg <= b_y_reg))
                   || ((py_reg >= b_y_reg) && (py_reg <= rd_y_reg));
    assign straddle = (rd_y_reg > py_reg) != (b_y_reg > py_reg);
    assign dy_pos   = b_y_reg > rd_y_reg;

    // keep the previous vertex and form the two products
    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            b_x_reg <= rd_x_reg;
            b_y_reg <= rd_y_reg;
        end
        lhs_reg      <= dxpa * dyba;
        rhs_reg      <= dxba * dypa;
        bbox_reg     <= bbox_x && bbox_y;
        straddle_reg <= straddle;
        dy_pos_reg   <= dy_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg    <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg    <= s1_v_reg && !s1_first_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: on-edge flag and crossing parity
    assign same      = (lhs_reg == rhs_reg);
    assign hit       = dy_pos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
    assign edge_next = edge_reg || (same && bbox_reg);
    assign par_next  = par_reg ^ (straddle_reg && hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg <= 1'b0;
            par_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (load_query)
            begin
                edge_reg <= 1'b0;
                par_reg  <= 1'b0;
            end
            else if (s2_v_reg)
            begin
                edge_reg <= edge_next;
                par_reg  <= par_next;
            end
            done_reg <= (s2_v_reg && s2_last_reg) || empty_query;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (empty_query)
        begin
            inside_reg <= 1'b0;
            on_reg     <= 1'b0;
        end
        else if (s2_v_reg && s2_last_reg)
        begin
            inside_reg <= edge_next || par_next;
            on_reg     <= edge_next;
        end
    end

    assign done        = done_reg;
    assign inside_res  = inside_reg;
    assign on_boundary = on_reg;

endmodule

`default_nettype wire
